// ===== rtl/length_field_frame_receiver_defines.svh =====
// Assertion macros shared by the length-field frame receiver RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LENGTH_FIELD_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_FIELD_FRAME_RECEIVER_DEFINES_SVH

// Plain property under clock and active-low reset.
`define LFFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication under clock and active-low reset.
`define LFFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under clock and active-low reset.
`define LFFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lffr_pkg.sv =====
// Types and constants of the length-field frame receiver.
// No dependencies; used by lffr_core, length_field_frame_receiver and the testbench.
package lffr_pkg;

  localparam int unsigned MaxFrameDefault  = 1024;
  localparam logic [7:0]  TimeoutReset     = 8'd10;
  localparam int unsigned FrameOverhead    = 10;

  localparam logic [7:0]  Hdr0ByteA        = 8'hAA;
  localparam logic [7:0]  Hdr0ByteB        = 8'hAB;
  localparam logic [7:0]  Hdr1ByteA        = 8'hBB;
  localparam logic [7:0]  Hdr1ByteB        = 8'hBC;
  localparam logic [7:0]  Hdr2Byte         = 8'hCC;

  localparam int unsigned Hdr0Pos          = 0;
  localparam int unsigned Hdr1Pos          = 1;
  localparam int unsigned Hdr2Pos          = 2;
  localparam int unsigned LenHiPos         = 3;
  localparam int unsigned LenLoPos         = 4;
  localparam int unsigned ChkHiPos         = 5;
  localparam int unsigned ChkLoPos         = 6;

  localparam int unsigned FuncByte         = 0;
  localparam int unsigned FuncTick         = 1;

  localparam logic [2:0]  RegTimeoutAddr   = 3'd0;

  typedef struct packed {
    logic        kept;
    logic [9:0]  index;
    logic [7:0]  value;
    logic        done;
    logic [10:0] length;
  } lffr_result_t;

endpackage

// ===== rtl/lffr_core.sv =====
// Frame parser of the length-field frame receiver: position, idle countdown,
// header and length checks. Depends on lffr_pkg.
module lffr_core #(
  parameter int unsigned MaxFrame = lffr_pkg::MaxFrameDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 func_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           timeout_i,
  output lffr_pkg::lffr_result_t result_o
);
  import lffr_pkg::*;

  localparam int unsigned PosW = $clog2(MaxFrame + 1);
  localparam int unsigned LenW = 17;

  logic [PosW-1:0] pos_q, pos_d, exp_q, exp_d;
  logic [PosW-1:0] pos_eff, pos_inc;
  logic [7:0]      cnt_q, cnt_d;
  logic [7:0]      len_hi_q, len_hi_d, len_lo_q, len_lo_d, chk_hi_q, chk_hi_d;
  logic [15:0]     len_word, chk_word;
  logic [LenW-1:0] len_total;
  logic            len_ok, kept, done, is_tick;

  always_comb begin
    is_tick   = (func_i == 1'(FuncTick));
    pos_eff   = (cnt_q == 8'd0) ? '0 : pos_q;
    pos_inc   = pos_eff + PosW'(1);
    len_word  = {len_hi_q, len_lo_q};
    chk_word  = {chk_hi_q, rx_byte_i};
    len_total = {1'b0, len_word} + LenW'(FrameOverhead);
    len_ok    = ((len_word & chk_word) == 16'd0) && (len_total <= LenW'(MaxFrame));

    kept     = 1'b1;
    exp_d    = exp_q;
    len_hi_d = len_hi_q;
    len_lo_d = len_lo_q;
    chk_hi_d = chk_hi_q;
    unique case (pos_eff)
      PosW'(Hdr0Pos): begin
        kept = (rx_byte_i == Hdr0ByteA) || (rx_byte_i == Hdr0ByteB);
      end
      PosW'(Hdr1Pos): begin
        kept = (rx_byte_i == Hdr1ByteA) || (rx_byte_i == Hdr1ByteB);
      end
      PosW'(Hdr2Pos): begin
        kept = (rx_byte_i == Hdr2Byte);
      end
      PosW'(LenHiPos): begin
        len_hi_d = rx_byte_i;
      end
      PosW'(LenLoPos): begin
        len_lo_d = rx_byte_i;
      end
      PosW'(ChkHiPos): begin
        chk_hi_d = rx_byte_i;
      end
      PosW'(ChkLoPos): begin
        kept = len_ok;
        if (len_ok) begin
          exp_d = len_total[PosW-1:0];
        end
      end
      default: begin
        kept = 1'b1;
      end
    endcase

    done = kept && (pos_eff > PosW'(ChkLoPos)) && (pos_inc >= exp_q);

    if (is_tick) begin
      cnt_d = (cnt_q != 8'd0) ? cnt_q - 8'd1 : cnt_q;
      pos_d = pos_q;
    end else begin
      cnt_d = timeout_i;
      pos_d = (!kept || done) ? '0 : pos_inc;
    end

    result_o.kept   = !is_tick && kept;
    result_o.index  = (!is_tick && kept) ? 10'(pos_eff) : 10'd0;
    result_o.value  = (!is_tick && kept) ? rx_byte_i : 8'd0;
    result_o.done   = !is_tick && done;
    result_o.length = (!is_tick && done) ? 11'(exp_q) : 11'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cnt_q    <= '0;
      exp_q    <= PosW'(MaxFrame);
      len_hi_q <= '0;
      len_lo_q <= '0;
      chk_hi_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      if (!is_tick) begin
        exp_q    <= exp_d;
        len_hi_q <= len_hi_d;
        len_lo_q <= len_lo_d;
        chk_hi_q <= chk_hi_d;
      end
    end
  end

endmodule

// ===== rtl/length_field_frame_receiver.sv =====
// Top level of the length-field frame receiver: configuration port, handshake
// and result register. Depends on lffr_pkg, lffr_core and the defines header.
//
// The receiver takes one word (a received byte or a millisecond tick) in each
// cycle in which in_stall_o is low, and gives exactly one result word per input
// word, in the cycle after it is taken. The parser checks a word combinationally,
// so the rate is one word per cycle unless stalled; in_stall_o is high only while
// a result is held in the output register and the output side stalls.
`include "length_field_frame_receiver_defines.svh"

module length_field_frame_receiver #(
  parameter int unsigned MaxFrame = lffr_pkg::MaxFrameDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        byte_kept_o,
  output logic [9:0]  byte_index_o,
  output logic [7:0]  byte_value_o,
  output logic        frame_done_o,
  output logic [10:0] frame_length_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lffr_pkg::*;

  logic         in_accept, cfg_write;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   timeout_q;
  lffr_result_t res_d, res_q;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == RegTimeoutAddr[2]) ? {24'd0, timeout_q} : 32'd0;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_d = in_accept ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  lffr_core #(
    .MaxFrame(MaxFrame)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .func_i    (func_i),
    .rx_byte_i (rx_byte_i),
    .timeout_i (timeout_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_write && (paddr[2] == RegTimeoutAddr[2])) begin
        timeout_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_kept_o    = res_q.kept;
  assign byte_index_o   = res_q.index;
  assign byte_value_o   = res_q.value;
  assign frame_done_o   = res_q.done;
  assign frame_length_o = res_q.length;

  `LFFR_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_accept, out_valid_q, "accepted word produced no result")
  `LFFR_ASSERT_IMP(a_done_is_kept, clk_i, rst_ni, out_valid_q && res_q.done, res_q.kept, "frame done on a dropped byte")
  `LFFR_ASSERT_IMP(a_dropped_is_zero, clk_i, rst_ni, out_valid_q && !res_q.kept, (res_q.index == 10'd0) && (res_q.value == 8'd0) && (res_q.length == 11'd0), "dropped byte has nonzero fields")
  `LFFR_ASSERT_IMP(a_tick_not_kept, clk_i, rst_ni, in_accept && (func_i == 1'(FuncTick)), !res_d.kept && !res_d.done, "tick produced a kept byte")

endmodule

// ===== tb/tb_length_field_frame_receiver.sv =====
// Testbench for length_field_frame_receiver: random frames, ticks and noise
// checked word by word against a built-in predictor of the deframer.
// Depends on lffr_pkg and the length_field_frame_receiver RTL.
module tb_length_field_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import lffr_pkg::*;

  localparam int unsigned StuckLimit = 2000;

  typedef struct {
    logic       func;
    logic [7:0] data;
  } rx_word_t;

  class frame_scoreboard;
    logic [7:0]   timeout_ticks;
    logic [10:0]  frame_pos;
    logic [7:0]   idle_left;
    logic [10:0]  frame_total;
    logic [7:0]   len_chk_bytes [3];
    lffr_result_t result_q [$];
    int           mismatches;

    function new();
      timeout_ticks = TimeoutReset;
      frame_pos = '0;
      idle_left = '0;
      frame_total = 11'(MaxFrameDefault);
      len_chk_bytes = '{default: '0};
      mismatches = 0;
    endfunction

    function void set_timeout(logic [7:0] ticks);
      timeout_ticks = ticks;
    endfunction

    function void note_word(logic func, logic [7:0] data);
      lffr_result_t res;
      logic [10:0]  idx;
      logic [15:0]  len_w;
      logic [15:0]  chk_w;
      int unsigned  total;
      bit           keep;
      res = '0;
      if (func == 1'(FuncTick)) begin
        if (idle_left != 0) idle_left--;
      end else begin
        if (idle_left == 0) frame_pos = '0;
        idle_left = timeout_ticks;
        idx = frame_pos;
        frame_pos++;
        keep = 1'b1;
        unique case (idx)
          11'(Hdr0Pos): keep = (data == Hdr0ByteA) || (data == Hdr0ByteB);
          11'(Hdr1Pos): keep = (data == Hdr1ByteA) || (data == Hdr1ByteB);
          11'(Hdr2Pos): keep = (data == Hdr2Byte);
          11'(LenHiPos), 11'(LenLoPos), 11'(ChkHiPos):
            len_chk_bytes[2'(idx - 11'(LenHiPos))] = data;
          11'(ChkLoPos): begin
            len_w = {len_chk_bytes[0], len_chk_bytes[1]};
            chk_w = {len_chk_bytes[2], data};
            total = len_w + FrameOverhead;
            if ((len_w & chk_w) != 0 || total > MaxFrameDefault) keep = 1'b0;
            else frame_total = 11'(total);
          end
          default: ;
        endcase
        if (!keep) begin
          frame_pos = '0;
        end else begin
          res.kept = 1'b1;
          res.index = idx[9:0];
          res.value = data;
          if (frame_pos > ChkLoPos + 1 && frame_pos >= frame_total) begin
            res.done = 1'b1;
            res.length = frame_total;
            frame_pos = '0;
          end
        end
      end
      result_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(lffr_result_t got);
      lffr_result_t exp_res;
      if (result_q.size() == 0) begin
        $error("Result word arrived with no word pending.");
        mismatches++;
        return;
      end
      exp_res = result_q.pop_front();
      compare_field("byte_kept", 32'(exp_res.kept), 32'(got.kept));
      compare_field("byte_index", 32'(exp_res.index), 32'(got.index));
      compare_field("byte_value", 32'(exp_res.value), 32'(got.value));
      compare_field("frame_done", 32'(exp_res.done), 32'(got.done));
      compare_field("frame_length", 32'(exp_res.length), 32'(got.length));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        byte_kept_o;
  logic [9:0]  byte_index_o;
  logic [7:0]  byte_value_o;
  logic        frame_done_o;
  logic [10:0] frame_length_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb = new();
  rx_word_t        word_q [$];
  int unsigned     pushed_words = 0;
  bit              idling_on = 1'b1;
  bit              sprinkle_ticks = 1'b0;
  int unsigned     timeout_now = 32'(TimeoutReset);
  int unsigned     gap_left = 0;
  int unsigned     stall_left = 0;
  int unsigned     stuck_cycles = 0;

  length_field_frame_receiver #(
    .MaxFrame(MaxFrameDefault)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_kept_o   (byte_kept_o),
    .byte_index_o  (byte_index_o),
    .byte_value_o  (byte_value_o),
    .frame_done_o  (frame_done_o),
    .frame_length_o(frame_length_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rx_word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_word(func_i, rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (idling_on && gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() > 0) begin
          w = word_q.pop_front();
          in_valid_i <= 1'b1;
          func_i <= w.func;
          rx_byte_i <= w.data;
          if (idling_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(lffr_result_t'({byte_kept_o, byte_index_o, byte_value_o,
                                        frame_done_o, frame_length_o}));
      end
      if (idling_on && stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else if (in_valid_i || word_q.size() > 0 || sb.result_q.size() > 0) begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  function automatic void push_tick();
    word_q.push_back('{func: 1'(FuncTick), data: 8'($urandom)});
    pushed_words++;
  endfunction

  function automatic void push_byte(logic [7:0] data);
    if (sprinkle_ticks && $urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 2)) push_tick();
    end
    word_q.push_back('{func: 1'(FuncByte), data: data});
    pushed_words++;
  endfunction

  function automatic void push_frame(logic [15:0] len_w, logic [15:0] chk_w,
                                     int unsigned payload);
    push_byte($urandom_range(0, 1) ? Hdr0ByteA : Hdr0ByteB);
    push_byte($urandom_range(0, 1) ? Hdr1ByteA : Hdr1ByteB);
    push_byte(Hdr2Byte);
    push_byte(len_w[15:8]);
    push_byte(len_w[7:0]);
    push_byte(chk_w[15:8]);
    push_byte(chk_w[7:0]);
    repeat (payload) push_byte(8'($urandom));
  endfunction

  function automatic void push_traffic(int unsigned count);
    int unsigned start;
    int unsigned sel;
    int unsigned bad_at;
    logic [15:0] len_w;
    logic [15:0] chk_w;
    logic [7:0]  hdr [3];
    start = pushed_words;
    while (pushed_words - start < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        len_w = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 60)) :
                                              16'($urandom_range(0, 10));
        chk_w = 16'($urandom) & ~len_w;
        push_frame(len_w, chk_w, len_w + 3);
      end else if (sel < 70) begin
        hdr[0] = $urandom_range(0, 1) ? Hdr0ByteA : Hdr0ByteB;
        hdr[1] = $urandom_range(0, 1) ? Hdr1ByteA : Hdr1ByteB;
        hdr[2] = Hdr2Byte;
        bad_at = $urandom_range(0, 2);
        hdr[2'(bad_at)] = 8'($urandom);
        for (int i = 0; i <= bad_at; i++) push_byte(hdr[2'(i)]);
      end else if (sel < 80) begin
        len_w = 16'($urandom_range(1, 65535));
        chk_w = 16'($urandom) | (len_w & (~len_w + 16'd1));
        push_frame(len_w, chk_w, 0);
      end else if (sel < 86) begin
        len_w = $urandom_range(0, 1) ? 16'd1015 : 16'($urandom_range(1015, 65535));
        chk_w = 16'($urandom) & ~len_w;
        push_frame(len_w, chk_w, 0);
      end else if (sel < 93) begin
        repeat ($urandom_range(1, timeout_now + 2)) push_tick();
      end else begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      end
    end
  endfunction

  task automatic write_timeout(logic [7:0] ticks);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegTimeoutAddr;
    pwdata <= 32'(ticks);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_timeout(ticks);
    timeout_now = 32'(ticks);
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid_i || sb.result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] timeout_plan [6];
    rst_ni <= 1'b0;
    timeout_plan = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd3, TimeoutReset};
    timeout_plan[3] = 8'($urandom_range(2, 254));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Shortest legal frame, ticks, broken headers, overlapping and oversized lengths.
    push_frame(16'h0000, 16'h0000, 0);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h80);
    push_tick();
    push_tick();
    push_byte(8'h00);
    push_byte(Hdr0ByteB);
    push_byte(Hdr1ByteB);
    push_byte(8'h55);
    push_frame(16'h0001, 16'h0001, 0);
    push_frame(16'hFFFF, 16'h0000, 0);
    wait_drained();

    sprinkle_ticks = 1'b1;
    for (int p = 0; p < 6; p++) begin
      write_timeout(timeout_plan[3'(p)]);
      idling_on = (p != 5);
      push_traffic(45);
      if (p == 0) begin
        push_frame(16'd1014, 16'($urandom) & ~16'd1014, 5);
        push_tick();
        push_tick();
      end
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== length_field_frame_receiver.f =====
+incdir+rtl
rtl/lffr_pkg.sv
rtl/lffr_core.sv
rtl/length_field_frame_receiver.sv
tb/tb_length_field_frame_receiver.sv
